@@ hw/rtl/rfd_pkg.sv @@
// Shared types and constants for the radio frame record deframer.
package rfd_pkg;

    localparam logic [7:0] MIN_HEADER   = 8'd2;
    localparam logic [7:0] POS_MAX      = 8'hFF;
    localparam logic [7:0] TYPE_WORD16  = 8'd2;
    localparam logic [7:0] TYPE_WORD32  = 8'd3;
    localparam logic [2:0] LEN_BYTE     = 3'd1;
    localparam logic [2:0] LEN_WORD16   = 3'd2;
    localparam logic [2:0] LEN_WORD32   = 3'd4;
    localparam logic       KIND_REALTIME = 1'b0;
    localparam logic       KIND_RECORD   = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rfd_in_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  slot;
        logic [7:0]  value_type;
        logic [31:0] value_word;
        logic [2:0]  value_bytes;
        logic        frame_done;
    } rfd_out_t;

    typedef struct packed {
        logic fire;
        logic emit;
    } rfd_flow_t;

    function automatic logic [2:0] type_length(input logic [7:0] t);
        logic [2:0] len;
        len = LEN_BYTE;
        if (t == TYPE_WORD16)
        begin
            len = LEN_WORD16;
        end
        else if (t == TYPE_WORD32)
        begin
            len = LEN_WORD32;
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/rfd_input_stage.sv @@
// Input register holding one received byte request until the parser takes it.
module rfd_input_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rx_valid,
    output logic            rx_ready,
    input  rfd_pkg::rfd_in_t rx_data,
    input  logic            take,
    output logic            item_valid,
    output rfd_pkg::rfd_in_t item_data
);

    logic             valid_reg;
    logic             valid_next;
    rfd_pkg::rfd_in_t data_reg;

    assign rx_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx_valid && rx_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            data_reg <= rx_data;
        end
    end

endmodule

@@ hw/rtl/rfd_parser.sv @@
// Frame parser: position tracking, record assembly and result formation.
module rfd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  rfd_pkg::rfd_in_t  item_data,
    input  logic              load_ok,
    output rfd_pkg::rfd_flow_t flow,
    output rfd_pkg::rfd_out_t result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_KEY   = 2'd1,
        PH_TYPE  = 2'd2,
        PH_VALUE = 2'd3
    } phase_t;

    logic [7:0]  position_reg,  position_next;
    logic [7:0]  left_reg,      left_next;
    logic [7:0]  start_reg,     start_next;
    phase_t      phase_reg,     phase_next;
    logic [7:0]  key_reg,       key_next;
    logic [7:0]  type_reg,      type_next;
    logic [31:0] acc_reg,       acc_next;
    logic [2:0]  bytes_reg,     bytes_next;

    logic [7:0]  pos;
    logic [7:0]  rx;
    logic [2:0]  len;
    logic [2:0]  bleft;
    logic [2:0]  offset;
    logic [31:0] acc_merged;
    logic [7:0]  rec_left_dec;
    logic        emit;

    assign rx = item_data.rx_byte;
    assign pos = item_data.frame_start ? 8'd0 : position_reg;
    assign len = rfd_pkg::type_length(type_reg);
    assign bleft = (bytes_reg == 3'd0 || bytes_reg > len) ? len : bytes_reg;
    assign offset = len - bleft;
    assign acc_merged = acc_reg | ({24'd0, rx} << {offset[1:0], 3'b000});
    assign rec_left_dec = left_reg - 8'd1;

    always_comb
    begin
        position_next = position_reg;
        left_next     = left_reg;
        start_next    = start_reg;
        phase_next    = phase_reg;
        key_next      = key_reg;
        type_next     = type_reg;
        acc_next      = acc_reg;
        bytes_next    = bytes_reg;
        emit          = 1'b0;
        result        = '0;

        if (pos == 8'd0)
        begin
            left_next  = rx;
            start_next = rfd_pkg::MIN_HEADER;
            phase_next = PH_IDLE;
            key_next   = 8'd0;
            type_next  = 8'd0;
            acc_next   = 32'd0;
            bytes_next = 3'd0;
        end
        else if (pos == 8'd1)
        begin
            start_next = (rx < rfd_pkg::MIN_HEADER) ? rfd_pkg::MIN_HEADER : rx;
        end
        else if (pos < start_reg)
        begin
            emit               = 1'b1;
            result.item_kind   = rfd_pkg::KIND_REALTIME;
            result.slot        = pos - rfd_pkg::MIN_HEADER;
            result.value_type  = 8'd0;
            result.value_word  = {24'd0, rx};
            result.value_bytes = rfd_pkg::LEN_BYTE;
            result.frame_done  = 1'b0;
        end
        else if (left_reg != 8'd0)
        begin
            unique case (phase_reg)
                PH_IDLE, PH_KEY:
                begin
                    key_next   = rx;
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = rx;
                    bytes_next = rfd_pkg::type_length(rx);
                    acc_next   = 32'd0;
                    phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    acc_next   = acc_merged;
                    bytes_next = bleft - 3'd1;
                    if (bleft == 3'd1)
                    begin
                        left_next          = rec_left_dec;
                        phase_next         = PH_KEY;
                        emit               = 1'b1;
                        result.item_kind   = rfd_pkg::KIND_RECORD;
                        result.slot        = key_reg;
                        result.value_type  = type_reg;
                        result.value_word  = acc_merged;
                        result.value_bytes = len;
                        result.frame_done  = (rec_left_dec == 8'd0);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        position_next = (pos != rfd_pkg::POS_MAX) ? pos + 8'd1 : pos;
    end

    assign flow.emit = item_valid && emit;
    assign flow.fire = item_valid && (!emit || load_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 8'd0;
            left_reg     <= 8'd0;
            start_reg    <= rfd_pkg::MIN_HEADER;
            phase_reg    <= PH_IDLE;
            key_reg      <= 8'd0;
            type_reg     <= 8'd0;
            acc_reg      <= 32'd0;
            bytes_reg    <= 3'd0;
        end
        else if (flow.fire)
        begin
            position_reg <= position_next;
            left_reg     <= left_next;
            start_reg    <= start_next;
            phase_reg    <= phase_next;
            key_reg      <= key_next;
            type_reg     <= type_next;
            acc_reg      <= acc_next;
            bytes_reg    <= bytes_next;
        end
    end

endmodule

@@ hw/rtl/rfd_output_stage.sv @@
// Result register presenting one decoded request to the downstream side.
module rfd_output_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rfd_pkg::rfd_out_t load_data,
    output logic              load_ok,
    output logic              rec_valid,
    input  logic              rec_ready,
    output rfd_pkg::rfd_out_t rec_data
);

    logic              valid_reg;
    logic              valid_next;
    rfd_pkg::rfd_out_t data_reg;

    assign load_ok   = !valid_reg || rec_ready;
    assign rec_valid = valid_reg;
    assign rec_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

@@ hw/rtl/radio_frame_record_deframer_unit.sv @@
// Top level of the radio frame record deframer.
//
//  channel | signals                        | carries
//  --------+--------------------------------+------------------------------
//  rx      | rx_valid, rx_ready, rx_data    | one frame byte, start flag
//  rec     | rec_valid, rec_ready, rec_data | realtime byte or record result
//
// One byte per cycle unless a stalled result holds a byte that has a result;
// a byte waits in the input register until the parser takes it, and its result,
// if any, is loaded into the result register by the combinational parser step.
// Reset clears handshake state and the parser position; no clearing pass.
// A stalled result blocks only bytes that produce a result; others pass.
module radio_frame_record_deframer_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  rfd_pkg::rfd_in_t  rx_data,
    output logic              rec_valid,
    input  logic              rec_ready,
    output rfd_pkg::rfd_out_t rec_data
);

    logic               item_valid;
    rfd_pkg::rfd_in_t   item_data;
    logic               load_ok;
    rfd_pkg::rfd_flow_t flow;
    rfd_pkg::rfd_out_t  result;

    rfd_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_data    (rx_data),
        .take       (flow.fire),
        .item_valid (item_valid),
        .item_data  (item_data)
    );

    rfd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_data  (item_data),
        .load_ok    (load_ok),
        .flow       (flow),
        .result     (result)
    );

    rfd_output_stage u_output
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (flow.emit && flow.fire),
        .load_data  (result),
        .load_ok    (load_ok),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_data   (rec_data)
    );

    a_done_is_record: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.frame_done |-> rec_data.item_kind == rfd_pkg::KIND_RECORD)
        else $error("frame_done on a realtime request");

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (rec_data.value_bytes == rfd_pkg::LEN_BYTE ||
                       rec_data.value_bytes == rfd_pkg::LEN_WORD16 ||
                       rec_data.value_bytes == rfd_pkg::LEN_WORD32))
        else $error("illegal value length");

    a_realtime_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.item_kind == rfd_pkg::KIND_REALTIME |->
            rec_data.value_type == 8'd0 && rec_data.value_word[31:8] == 24'd0)
        else $error("malformed realtime request");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !flow.fire |=> item_valid && $stable(item_data))
        else $error("pending byte lost before parsing");

endmodule
